// ===== hw/rtl/cmta_pkg.sv =====
// Shared types and constants for the cube map texel address block.
package cmta_pkg;

   // Default values for the top-level parameters.
   localparam int CMTA_COMPONENT_BITS = 16;
   localparam int CMTA_MAX_FACE_SIZE  = 4096;

   // Fixed field widths of the register and result ports.
   localparam int CMTA_CFG_BITS   = 13;
   localparam int CMTA_TEXEL_BITS = 12;
   localparam int CMTA_DATA_BITS  = 32;
   localparam int CMTA_ADDR_BITS  = 3;

   // Reset value of both face size registers.
   localparam logic [CMTA_CFG_BITS-1:0] CMTA_SIZE_RESET = 13'd256;

   // Cube face codes.
   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } cmta_face_type;

   // Register indexes, selected by address bit 2.
   typedef enum logic [0:0] {
      REG_FACE_WIDTH  = 1'b0,
      REG_FACE_HEIGHT = 1'b1
   } cmta_reg_index_type;

   // Control that travels alongside each transaction down the pipeline.
   typedef struct packed {
      logic          valid;
      cmta_face_type face;
      logic          degenerate;
   } cmta_tag_type;

endpackage

// ===== hw/rtl/cmta_front.sv =====
// Face selection, in-face numerators and scaling by the face size.
module cmta_front
   import cmta_pkg::*;
#(
   parameter int COMP_BITS = CMTA_COMPONENT_BITS,
   parameter int SIZE_BITS = $clog2(CMTA_MAX_FACE_SIZE + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [COMP_BITS-1:0]     dir_x,
   input  logic signed [COMP_BITS-1:0]     dir_y,
   input  logic signed [COMP_BITS-1:0]     dir_z,
   input  logic [SIZE_BITS-1:0]            width_eff,
   input  logic [SIZE_BITS-1:0]            height_eff,
   output cmta_tag_type                    tag_o,
   output logic [COMP_BITS+SIZE_BITS:0]    num_u_o,
   output logic [COMP_BITS+SIZE_BITS:0]    num_v_o,
   output logic [COMP_BITS:0]              div_o
);

   localparam int ExtBits = COMP_BITS + 2;
   localparam int NumBits = COMP_BITS + SIZE_BITS + 1;

   logic [COMP_BITS-1:0]      mag_x;
   logic [COMP_BITS-1:0]      mag_y;
   logic [COMP_BITS-1:0]      mag_z;
   logic signed [ExtBits-1:0] ext_x;
   logic signed [ExtBits-1:0] ext_y;
   logic signed [ExtBits-1:0] ext_z;
   logic signed [ExtBits-1:0] num_u_s;
   logic signed [ExtBits-1:0] num_v_s;
   logic signed [ExtBits-1:0] mag_s;
   logic signed [ExtBits-1:0] sum_u_s;
   logic signed [ExtBits-1:0] sum_v_s;
   logic [COMP_BITS-1:0]      major;
   cmta_face_type             face;

   cmta_tag_type              tag2_in, tag2_ff;
   logic [COMP_BITS:0]        sum_u_in, sum_u_ff;
   logic [COMP_BITS:0]        sum_v_in, sum_v_ff;
   logic [COMP_BITS:0]        div2_in, div2_ff;
   cmta_tag_type              tag3_in, tag3_ff;
   logic [NumBits-1:0]        num_u_in, num_u_ff;
   logic [NumBits-1:0]        num_v_in, num_v_ff;
   logic [COMP_BITS:0]        div3_in, div3_ff;

   // Magnitudes; the most negative component maps to its true magnitude.
   assign mag_x = dir_x[COMP_BITS-1] ? (~dir_x + 1'b1) : dir_x;
   assign mag_y = dir_y[COMP_BITS-1] ? (~dir_y + 1'b1) : dir_y;
   assign mag_z = dir_z[COMP_BITS-1] ? (~dir_z + 1'b1) : dir_z;

   assign ext_x = ExtBits'(dir_x);
   assign ext_y = ExtBits'(dir_y);
   assign ext_z = ExtBits'(dir_z);

   // Major axis pick with ties going to x, then y; signed numerators per face.
   always_comb begin
      if (mag_x >= mag_y && mag_x >= mag_z) begin
         major = mag_x;
         face    = dir_x[COMP_BITS-1] ? FACE_NEG_X : FACE_POS_X;
         num_u_s = dir_x[COMP_BITS-1] ? ext_z : -ext_z;
         num_v_s = ext_y;
      end else if (mag_y >= mag_z) begin
         major = mag_y;
         face    = dir_y[COMP_BITS-1] ? FACE_NEG_Y : FACE_POS_Y;
         num_u_s = ext_x;
         num_v_s = dir_y[COMP_BITS-1] ? ext_z : -ext_z;
      end else begin
         major = mag_z;
         face    = dir_z[COMP_BITS-1] ? FACE_NEG_Z : FACE_POS_Z;
         num_u_s = dir_z[COMP_BITS-1] ? -ext_x : ext_x;
         num_v_s = ext_y;
      end
   end

   // Offset the numerators by the major magnitude; the sums lie in 0 to 2d.
   assign mag_s   = $signed({2'b00, major});
   assign sum_u_s = mag_s + num_u_s;
   assign sum_v_s = mag_s + num_v_s;

   always_comb begin
      tag2_in.valid      = start;
      tag2_in.face       = face;
      tag2_in.degenerate = (major == '0);
      sum_u_in           = sum_u_s[COMP_BITS:0];
      sum_v_in           = sum_v_s[COMP_BITS:0];
      div2_in            = {major, 1'b0};
   end

   // Scale by the face sizes; the divisor rides along unchanged.
   always_comb begin
      tag3_in  = tag2_ff;
      num_u_in = NumBits'(sum_u_ff) * NumBits'(width_eff);
      num_v_in = NumBits'(sum_v_ff) * NumBits'(height_eff);
      div3_in  = div2_ff;
   end

   // Pipeline registers; only the transaction tag is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag2_ff <= tag2_in;
         tag3_ff <= tag3_in;
      end
      sum_u_ff <= sum_u_in;
      sum_v_ff <= sum_v_in;
      div2_ff  <= div2_in;
      num_u_ff <= num_u_in;
      num_v_ff <= num_v_in;
      div3_ff  <= div3_in;
   end

   assign tag_o   = tag3_ff;
   assign num_u_o = num_u_ff;
   assign num_v_o = num_v_ff;
   assign div_o   = div3_ff;

endmodule

// ===== hw/rtl/cmta_div_cell.sv =====
// One cell of the divider chain: one quotient bit for the column and row lanes.
module cmta_div_cell
   import cmta_pkg::*;
#(
   parameter int REM_BITS = CMTA_COMPONENT_BITS + 1,
   parameter int QUO_BITS = $clog2(CMTA_MAX_FACE_SIZE + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  cmta_tag_type        tag_i,
   input  logic [REM_BITS-1:0] div_i,
   input  logic [REM_BITS-1:0] rem_u_i,
   input  logic [REM_BITS-1:0] rem_v_i,
   input  logic [QUO_BITS-1:0] low_u_i,
   input  logic [QUO_BITS-1:0] low_v_i,
   input  logic [QUO_BITS-1:0] quo_u_i,
   input  logic [QUO_BITS-1:0] quo_v_i,
   output cmta_tag_type        tag_o,
   output logic [REM_BITS-1:0] div_o,
   output logic [REM_BITS-1:0] rem_u_o,
   output logic [REM_BITS-1:0] rem_v_o,
   output logic [QUO_BITS-1:0] low_u_o,
   output logic [QUO_BITS-1:0] low_v_o,
   output logic [QUO_BITS-1:0] quo_u_o,
   output logic [QUO_BITS-1:0] quo_v_o
);

   logic [REM_BITS:0]   trial_u;
   logic [REM_BITS:0]   trial_v;
   logic [REM_BITS:0]   div_ext;
   logic [REM_BITS:0]   diff_u;
   logic [REM_BITS:0]   diff_v;
   logic                fits_u;
   logic                fits_v;

   cmta_tag_type        tag_in, tag_ff;
   logic [REM_BITS-1:0] div_in, div_ff;
   logic [REM_BITS-1:0] rem_u_in, rem_u_ff;
   logic [REM_BITS-1:0] rem_v_in, rem_v_ff;
   logic [QUO_BITS-1:0] low_u_in, low_u_ff;
   logic [QUO_BITS-1:0] low_v_in, low_v_ff;
   logic [QUO_BITS-1:0] quo_u_in, quo_u_ff;
   logic [QUO_BITS-1:0] quo_v_in, quo_v_ff;

   // Bring down the next dividend bit and try a subtraction in each lane.
   assign div_ext = {1'b0, div_i};
   assign trial_u = {rem_u_i, low_u_i[QUO_BITS-1]};
   assign trial_v = {rem_v_i, low_v_i[QUO_BITS-1]};
   assign fits_u  = (trial_u >= div_ext);
   assign fits_v  = (trial_v >= div_ext);
   assign diff_u  = trial_u - div_ext;
   assign diff_v  = trial_v - div_ext;

   // Keep the partial remainder below the divisor and shift in the quotient bit.
   always_comb begin
      tag_in   = tag_i;
      div_in   = div_i;
      rem_u_in = fits_u ? diff_u[REM_BITS-1:0] : trial_u[REM_BITS-1:0];
      rem_v_in = fits_v ? diff_v[REM_BITS-1:0] : trial_v[REM_BITS-1:0];
      low_u_in = {low_u_i[QUO_BITS-2:0], 1'b0};
      low_v_in = {low_v_i[QUO_BITS-2:0], 1'b0};
      quo_u_in = {quo_u_i[QUO_BITS-2:0], fits_u};
      quo_v_in = {quo_v_i[QUO_BITS-2:0], fits_v};
   end

   // Cell registers; only the transaction tag is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
      div_ff   <= div_in;
      rem_u_ff <= rem_u_in;
      rem_v_ff <= rem_v_in;
      low_u_ff <= low_u_in;
      low_v_ff <= low_v_in;
      quo_u_ff <= quo_u_in;
      quo_v_ff <= quo_v_in;
   end

   assign tag_o   = tag_ff;
   assign div_o   = div_ff;
   assign rem_u_o = rem_u_ff;
   assign rem_v_o = rem_v_ff;
   assign low_u_o = low_u_ff;
   assign low_v_o = low_v_ff;
   assign quo_u_o = quo_u_ff;
   assign quo_v_o = quo_v_ff;

endmodule

// ===== hw/rtl/cube_map_texel_address_top.sv =====
// Cube map face selection and texel addressing: top level with register port.
//
// One direction vector is accepted in every clock cycle; start is taken
// whenever it is high, since busy is always low. Each transaction produces one
// result, shown for a single cycle with rsp_valid high. The pipeline is made
// of the face selection and face size scaling stages, the divider chain, which
// resolves one quotient bit per cell for both texel coordinates, and the
// output stage. The receiver must take every result in the cycle it appears.
// The user must write the face size registers only while no transaction is in
// flight; the block itself does not enforce this.
module cube_map_texel_address_top
   import cmta_pkg::*;
#(
   parameter int COMPONENT_BITS = CMTA_COMPONENT_BITS,
   parameter int MAX_FACE_SIZE  = CMTA_MAX_FACE_SIZE
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COMPONENT_BITS-1:0]  req_dir_x,
   input  logic signed [COMPONENT_BITS-1:0]  req_dir_y,
   input  logic signed [COMPONENT_BITS-1:0]  req_dir_z,
   // Result channel.
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_face,
   output logic [CMTA_TEXEL_BITS-1:0]        rsp_texel_col,
   output logic [CMTA_TEXEL_BITS-1:0]        rsp_texel_row,
   output logic                              rsp_degenerate,
   // Register port.
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [CMTA_ADDR_BITS-1:0]         paddr,
   input  logic [CMTA_DATA_BITS-1:0]         pwdata,
   output logic [CMTA_DATA_BITS-1:0]         prdata,
   output logic                              pready
);

   localparam int SizeBits = $clog2(MAX_FACE_SIZE + 1);
   localparam int RemBits  = COMPONENT_BITS + 1;
   localparam int NumBits  = COMPONENT_BITS + SizeBits + 1;
   localparam int Latency  = SizeBits + 3;

   logic [CMTA_CFG_BITS-1:0] face_width_in, face_width_ff;
   logic [CMTA_CFG_BITS-1:0] face_height_in, face_height_ff;
   logic                     csr_write;
   cmta_reg_index_type       csr_index;
   logic [SizeBits-1:0]      width_eff;
   logic [SizeBits-1:0]      height_eff;

   cmta_tag_type             front_tag;
   logic [NumBits-1:0]       front_num_u;
   logic [NumBits-1:0]       front_num_v;
   logic [RemBits-1:0]       front_div;

   cmta_tag_type             chain_tag   [0:SizeBits];
   logic [RemBits-1:0]       chain_div   [0:SizeBits];
   logic [RemBits-1:0]       chain_rem_u [0:SizeBits];
   logic [RemBits-1:0]       chain_rem_v [0:SizeBits];
   logic [SizeBits-1:0]      chain_low_u [0:SizeBits];
   logic [SizeBits-1:0]      chain_low_v [0:SizeBits];
   logic [SizeBits-1:0]      chain_quo_u [0:SizeBits];
   logic [SizeBits-1:0]      chain_quo_v [0:SizeBits];

   logic [SizeBits-1:0]      col_idx;
   logic [SizeBits-1:0]      row_idx;
   logic                     out_valid_in, out_valid_ff;
   logic [2:0]               out_face_in, out_face_ff;
   logic [CMTA_TEXEL_BITS-1:0] out_col_in, out_col_ff;
   logic [CMTA_TEXEL_BITS-1:0] out_row_in, out_row_ff;
   logic                     out_deg_in, out_deg_ff;

   // Register port: writes complete in the access phase, no wait states.
   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = cmta_reg_index_type'(paddr[2]);

   always_comb begin
      face_width_in  = face_width_ff;
      face_height_in = face_height_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FACE_WIDTH:  face_width_in  = pwdata[CMTA_CFG_BITS-1:0];
            REG_FACE_HEIGHT: face_height_in = pwdata[CMTA_CFG_BITS-1:0];
            default: begin
               face_width_in  = face_width_ff;
               face_height_in = face_height_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FACE_WIDTH:  prdata = CMTA_DATA_BITS'(face_width_ff);
         REG_FACE_HEIGHT: prdata = CMTA_DATA_BITS'(face_height_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff  <= CMTA_SIZE_RESET;
         face_height_ff <= CMTA_SIZE_RESET;
      end else begin
         face_width_ff  <= face_width_in;
         face_height_ff <= face_height_in;
      end
   end

   // Effective face sizes: zero acts as one, oversize values cap at the maximum.
   always_comb begin
      if (face_width_ff == '0) begin
         width_eff = SizeBits'(1);
      end else if (32'(face_width_ff) > MAX_FACE_SIZE) begin
         width_eff = SizeBits'(MAX_FACE_SIZE);
      end else begin
         width_eff = SizeBits'(face_width_ff);
      end
      if (face_height_ff == '0) begin
         height_eff = SizeBits'(1);
      end else if (32'(face_height_ff) > MAX_FACE_SIZE) begin
         height_eff = SizeBits'(MAX_FACE_SIZE);
      end else begin
         height_eff = SizeBits'(face_height_ff);
      end
   end

   // Face selection and numerator scaling.
   cmta_front #(
      .COMP_BITS (COMPONENT_BITS),
      .SIZE_BITS (SizeBits)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .dir_x      (req_dir_x),
      .dir_y      (req_dir_y),
      .dir_z      (req_dir_z),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .tag_o      (front_tag),
      .num_u_o    (front_num_u),
      .num_v_o    (front_num_v),
      .div_o      (front_div)
   );

   // The upper dividend bits form the first partial remainder, below the divisor.
   assign chain_tag[0]   = front_tag;
   assign chain_div[0]   = front_div;
   assign chain_rem_u[0] = front_num_u[NumBits-1:SizeBits];
   assign chain_rem_v[0] = front_num_v[NumBits-1:SizeBits];
   assign chain_low_u[0] = front_num_u[SizeBits-1:0];
   assign chain_low_v[0] = front_num_v[SizeBits-1:0];
   assign chain_quo_u[0] = '0;
   assign chain_quo_v[0] = '0;

   // Divider chain, one quotient bit per cell.
   for (genvar g = 0; g < SizeBits; g++) begin : g_cell
      cmta_div_cell #(
         .REM_BITS (RemBits),
         .QUO_BITS (SizeBits)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tag_i   (chain_tag[g]),
         .div_i   (chain_div[g]),
         .rem_u_i (chain_rem_u[g]),
         .rem_v_i (chain_rem_v[g]),
         .low_u_i (chain_low_u[g]),
         .low_v_i (chain_low_v[g]),
         .quo_u_i (chain_quo_u[g]),
         .quo_v_i (chain_quo_v[g]),
         .tag_o   (chain_tag[g+1]),
         .div_o   (chain_div[g+1]),
         .rem_u_o (chain_rem_u[g+1]),
         .rem_v_o (chain_rem_v[g+1]),
         .low_u_o (chain_low_u[g+1]),
         .low_v_o (chain_low_v[g+1]),
         .quo_u_o (chain_quo_u[g+1]),
         .quo_v_o (chain_quo_v[g+1])
      );
   end

   // Clamp the far edge index to size minus one and zero a degenerate result.
   assign col_idx = (chain_quo_u[SizeBits] >= width_eff) ?
                    (width_eff - 1'b1) : chain_quo_u[SizeBits];
   assign row_idx = (chain_quo_v[SizeBits] >= height_eff) ?
                    (height_eff - 1'b1) : chain_quo_v[SizeBits];

   always_comb begin
      out_valid_in = chain_tag[SizeBits].valid;
      out_deg_in   = chain_tag[SizeBits].degenerate;
      if (chain_tag[SizeBits].degenerate) begin
         out_face_in = '0;
         out_col_in  = '0;
         out_row_in  = '0;
      end else begin
         out_face_in = chain_tag[SizeBits].face;
         out_col_in  = CMTA_TEXEL_BITS'(col_idx);
         out_row_in  = CMTA_TEXEL_BITS'(row_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_face_ff <= out_face_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_deg_ff  <= out_deg_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_face       = out_face_ff;
   assign rsp_texel_col  = out_col_ff;
   assign rsp_texel_row  = out_row_ff;
   assign rsp_degenerate = out_deg_ff;

   // Every accepted transaction comes out at the end of the pipeline.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##Latency rsp_valid)
      else $error("result missing after pipeline latency");

   // Texel indices stay inside the face after clamping.
   a_in_face : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |->
         (32'(rsp_texel_col) < 32'(width_eff)) && (32'(rsp_texel_row) < 32'(height_eff)))
      else $error("texel index outside the face");

   // A zero vector yields face and texel indices of zero.
   a_degenerate : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_face == 3'd0) && (rsp_texel_col == '0) && (rsp_texel_row == '0))
      else $error("degenerate result carries nonzero fields");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the cube map texel address block.
`timescale 1ns / 100ps

module tb_top
   import cmta_pkg::*;
();

   // One expected result transaction.
   typedef struct {
      cmta_face_type face;
      logic [CMTA_TEXEL_BITS-1:0] col;
      logic [CMTA_TEXEL_BITS-1:0] row;
      logic degenerate;
   } texel_result_type;

   // Predicts the face and texel address of each accepted direction and
   // compares the block's results against them in order.
   class texel_checker_type;
      logic [CMTA_CFG_BITS-1:0] face_w;
      logic [CMTA_CFG_BITS-1:0] face_h;
      texel_result_type expected_texels[$];
      int errors;

      function new();
         face_w = CMTA_SIZE_RESET;
         face_h = CMTA_SIZE_RESET;
         errors = 0;
      endfunction

      function void set_size(cmta_reg_index_type idx, logic [CMTA_CFG_BITS-1:0] value);
         if (idx == REG_FACE_WIDTH) begin
            face_w = value;
         end else begin
            face_h = value;
         end
      endfunction

      // A size of zero behaves as one; anything past the maximum is capped.
      function longint usable_size(logic [CMTA_CFG_BITS-1:0] s);
         if (s == 0) begin
            return 1;
         end
         if (s > CMTA_MAX_FACE_SIZE) begin
            return CMTA_MAX_FACE_SIZE;
         end
         return longint'(s);
      endfunction

      // floor((n + d) * w / (2d)), with the off-edge index pulled back in.
      function longint texel_index(longint n, longint d, longint w);
         longint idx;
         idx = ((n + d) * w) / (2 * d);
         if (idx >= w) begin
            idx = w - 1;
         end
         return idx;
      endfunction

      function texel_result_type predict_texel(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z);
         texel_result_type r;
         longint sx, sy, sz, ax, ay, az, major, nu, nv;
         sx = longint'(x);
         sy = longint'(y);
         sz = longint'(z);
         ax = (sx < 0) ? -sx : sx;
         ay = (sy < 0) ? -sy : sy;
         az = (sz < 0) ? -sz : sz;
         r.face = FACE_POS_X;
         r.col = '0;
         r.row = '0;
         r.degenerate = 1'b0;
         if (ax == 0 && ay == 0 && az == 0) begin
            r.degenerate = 1'b1;
            return r;
         end
         // Largest magnitude wins; ties favor x, then y.
         if (ax >= ay && ax >= az) begin
            major = ax;
            r.face = (sx >= 0) ? FACE_POS_X : FACE_NEG_X;
            nu = (sx >= 0) ? -sz : sz;
            nv = sy;
         end else if (ay >= az) begin
            major = ay;
            r.face = (sy >= 0) ? FACE_POS_Y : FACE_NEG_Y;
            nu = sx;
            nv = (sy >= 0) ? -sz : sz;
         end else begin
            major = az;
            r.face = (sz >= 0) ? FACE_POS_Z : FACE_NEG_Z;
            nu = (sz >= 0) ? sx : -sx;
            nv = sy;
         end
         r.col = CMTA_TEXEL_BITS'(texel_index(nu, major, usable_size(face_w)));
         r.row = CMTA_TEXEL_BITS'(texel_index(nv, major, usable_size(face_h)));
         return r;
      endfunction

      function void note_direction(logic signed [15:0] x, logic signed [15:0] y,
                                   logic signed [15:0] z);
         expected_texels.push_back(predict_texel(x, y, z));
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void check_texel(logic [2:0] face, logic [CMTA_TEXEL_BITS-1:0] col,
                                logic [CMTA_TEXEL_BITS-1:0] row, logic degenerate);
         texel_result_type want;
         if (expected_texels.size() == 0) begin
            report($sformatf("unexpected result: face %0d col %0d row %0d degenerate %0b",
                             face, col, row, degenerate));
            return;
         end
         want = expected_texels.pop_front();
         if (face !== want.face || col !== want.col || row !== want.row ||
             degenerate !== want.degenerate) begin
            report({$sformatf("mismatch: expected face %0d col %0d row %0d degenerate %0b,",
                              want.face, want.col, want.row, want.degenerate),
                    $sformatf(" got face %0d col %0d row %0d degenerate %0b",
                              face, col, row, degenerate)});
         end
      endfunction

      function int pending();
         return expected_texels.size();
      endfunction

      function void close_out();
         if (expected_texels.size() != 0) begin
            report($sformatf("%0d expected results never arrived", expected_texels.size()));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [15:0] req_dir_x;
   logic signed [15:0] req_dir_y;
   logic signed [15:0] req_dir_z;
   logic rsp_valid;
   logic [2:0] rsp_face;
   logic [CMTA_TEXEL_BITS-1:0] rsp_texel_col;
   logic [CMTA_TEXEL_BITS-1:0] rsp_texel_row;
   logic rsp_degenerate;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CMTA_ADDR_BITS-1:0] paddr;
   logic [CMTA_DATA_BITS-1:0] pwdata;
   logic [CMTA_DATA_BITS-1:0] prdata;
   logic pready;

   texel_checker_type texels = new();

   cube_map_texel_address_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .req_dir_z      (req_dir_z),
      .rsp_valid      (rsp_valid),
      .rsp_face       (rsp_face),
      .rsp_texel_col  (rsp_texel_col),
      .rsp_texel_row  (rsp_texel_row),
      .rsp_degenerate (rsp_degenerate),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watch both channels; outputs are sampled before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            texels.check_texel(rsp_face, rsp_texel_col, rsp_texel_row, rsp_degenerate);
         end
         if (start && !busy) begin
            texels.note_direction(req_dir_x, req_dir_y, req_dir_z);
         end
      end
   end

   // Present one direction and hold it until the block takes it.
   task send_dir(input logic signed [15:0] x, input logic signed [15:0] y,
                 input logic signed [15:0] z);
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task write_size(input cmta_reg_index_type idx, input logic [CMTA_CFG_BITS-1:0] value);
      logic [31:0] noise;
      noise = $urandom;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      // Bits above the register width are ignored by the block.
      pwdata <= {($urandom_range(0, 1) == 1) ? noise[31:13] : 19'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      texels.set_size(idx, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Stop sending and let every outstanding transaction come back.
   task drain_all;
      int waited;
      start <= 1'b0;
      waited = 0;
      while (texels.pending() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (24) @(posedge clock);
   endtask

   // Edges of the range, every face, tie breaks and the zero vector.
   task run_directed;
      send_dir(0, 0, 0);
      send_dir(32767, 0, 0);
      send_dir(-32768, 0, 0);
      send_dir(0, 32767, 0);
      send_dir(0, -32768, 0);
      send_dir(0, 0, 32767);
      send_dir(0, 0, -32768);
      send_dir(5, 5, 5);
      send_dir(-5, 5, -5);
      send_dir(0, 7, -7);
      send_dir(0, -7, 7);
      send_dir(3, 1, -3);
      send_dir(-1, -1, -1);
      send_dir(32767, 32767, 32767);
      send_dir(-32768, -32768, -32768);
      send_dir(-32768, 32767, -32767);
      send_dir(100, 100, -100);
      send_dir(100, -100, 100);
      send_dir(1, 0, 0);
      send_dir(-32767, 32767, 0);
      send_dir(12, -30000, 29999);
      send_dir(0, 0, -1);
      send_dir(-32768, -32768, 32767);
   endtask

   function automatic int pick_signed(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   // Mix of shapes: uniform, one dominant axis, ties, tiny and extreme values.
   function automatic void make_dir(output logic signed [15:0] x,
                                    output logic signed [15:0] y,
                                    output logic signed [15:0] z);
      int ext[6] = '{-32768, -32767, -1, 0, 1, 32767};
      int comp[3];
      int m;
      int axis;
      case ($urandom_range(0, 19)) inside
         0: begin
            comp = '{0, 0, 0};
         end
         [1:4]: begin
            comp[0] = $urandom;
            comp[1] = $urandom;
            comp[2] = $urandom;
         end
         [5:10]: begin
            m = $urandom_range(1, 32768);
            for (int i = 0; i < 3; i++) begin
               comp[i] = pick_signed(m);
               if (comp[i] > 32767) comp[i] = 32767;
            end
            axis = $urandom_range(0, 2);
            comp[axis] = (m == 32768 || $urandom_range(0, 1) == 1) ? -m : m;
         end
         [11:14]: begin
            m = $urandom_range(1, 32767);
            for (int i = 0; i < 3; i++) begin
               if ($urandom_range(0, 2) == 0) begin
                  comp[i] = pick_signed(m);
               end else begin
                  comp[i] = ($urandom_range(0, 1) == 1) ? m : -m;
               end
            end
         end
         [15:16]: begin
            for (int i = 0; i < 3; i++) comp[i] = pick_signed(3);
         end
         default: begin
            for (int i = 0; i < 3; i++) comp[i] = ext[$urandom_range(0, 5)];
         end
      endcase
      x = 16'(comp[0]);
      y = 16'(comp[1]);
      z = 16'(comp[2]);
   endfunction

   // Random directions sent in bursts with random gaps between them.
   task run_random(input int count);
      int sent;
      int burst;
      int gap;
      logic signed [15:0] x, y, z;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            make_dir(x, y, z);
            send_dir(x, y, z);
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Main sequence: reset, directed set, then random traffic over several sizes.
   initial begin
      int widths[7];
      int heights[7];
      int w;
      int h;
      widths = '{4096, 1, 0, 8191, 4095, 2, -1};
      heights = '{4096, 4096, 8191, 0, 3, 4097, -1};
      reset = 1'b1;
      start = 1'b0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(180);
      drain_all();

      for (int p = 0; p < 7; p++) begin
         w = (widths[p] < 0) ? $urandom_range(0, 8191) : widths[p];
         h = (heights[p] < 0) ? $urandom_range(0, 8191) : heights[p];
         write_size(REG_FACE_WIDTH, CMTA_CFG_BITS'(w));
         write_size(REG_FACE_HEIGHT, CMTA_CFG_BITS'(h));
         run_random(180);
         drain_all();
      end

      texels.close_out();
      if (texels.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
